### rtl/sbpc_pkg.sv
// Package for the stepper blind position controller.
// Holds widths, request/mode/direction codes, FSM states and the
// command/status structs shared by the controller and datapath.
package sbpc_pkg;

  localparam int SW     = 24;          // step counter width
  localparam int DIVN_W = SW + 7;      // signed dividend width (step * 100)
  localparam int CNT_W  = $clog2(DIVN_W + 1);
  localparam int IN_W   = 56;
  localparam int OUT_W  = 88;

  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam int          PCT_SCALE = 100;
  localparam int          LIMIT_RST = 10000;
  localparam logic [15:0] SPEED_RST = 16'd5;

  // x / 100 == (x * ceil(2^32 / 100)) >> 32, exact for x below 2^30
  localparam int               RCP_W   = 26;
  localparam int               RCP_SH  = 32;
  localparam logic [RCP_W-1:0] RCP_100 = 26'd42949673;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_TARGET = 3'd1,
    REQ_UP     = 3'd2,
    REQ_DOWN   = 3'd3,
    REQ_STOP   = 3'd4,
    REQ_OPEN   = 3'd5,
    REQ_CLOSED = 3'd6,
    REQ_LOAD   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    MODE_REST   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_t;

  typedef enum logic {
    DIR_UP   = 1'b0,
    DIR_DOWN = 1'b1
  } dir_t;

  typedef enum logic [1:0] {
    CFG_SPEED_UP   = 2'd0,
    CFG_SPEED_DOWN = 2'd1,
    CFG_INVERTED   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    SEL_TP = 1'b0,
    SEL_PP = 1'b1
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TGT,
    ST_TGW,
    ST_RCS,
    ST_RCT,
    ST_RCP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     in_ld;
    logic     exec;
    logic     div_start;
    div_sel_t div_sel;
    logic     tgt_wr;
    logic     tp_wr;
    logic     pp_wr;
    logic     out_wr;
  } cmd_t;

  typedef struct packed {
    req_t  req;
    mode_t mode;
    logic  div_done;
  } sts_t;

endpackage

### rtl/sbpc_div.sv
// Serial signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on sbpc_pkg for widths.
module sbpc_div import sbpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIVN_W-1:0] dividend,
  input  logic signed [SW-1:0]     divisor,
  output logic                     done,
  output logic signed [DIVN_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [SW-1:0]     dvs_r, dvs_nxt;
  logic [SW-1:0]     rem_r, rem_nxt;
  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [SW:0]       rem_sh;
  logic [SW:0]       rem_sub;
  logic              q_bit;

  assign rem_sh  = {rem_r, quo_r[DIVN_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[DIVN_W-1] ^ divisor[SW-1];
      dvs_nxt  = divisor[SW-1] ? SW'(-divisor) : SW'(divisor);
      quo_nxt  = dividend[DIVN_W-1] ? DIVN_W'(-dividend) : DIVN_W'(dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = q_bit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
      quo_nxt = {quo_r[DIVN_W-2:0], q_bit};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(quo_r) : signed'(quo_r);

endmodule

### rtl/sbpc_dp.sv
// Datapath: configuration registers, position state, percent logic, result register.
// Depends on sbpc_pkg and instantiates sbpc_div.
module sbpc_dp import sbpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [2:0]       in_tuser,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic [OUT_W-1:0] out_tdata
);

  // latched transaction
  req_t              req_r;
  logic [6:0]        tpct_r;
  logic signed [23:0] ld_step_r;
  logic signed [23:0] ld_lim_r;

  // configuration
  logic [15:0] spd_up_r, spd_up_nxt;
  logic [15:0] spd_dn_r, spd_dn_nxt;
  logic        inv_r, inv_nxt;

  // state
  logic signed [SW-1:0] pos_r, pos_nxt;
  logic signed [SW-1:0] tgt_r, tgt_nxt;
  logic signed [SW-1:0] lim_r, lim_nxt;
  mode_t                mode_r, mode_nxt;
  dir_t                 dir_r, dir_nxt;
  logic [7:0]           ppct_r, ppct_nxt;
  logic [7:0]           tpcr_r, tpcr_nxt;
  logic [7:0]           last_r, last_nxt;

  // per-item result flags
  logic [1:0]  mv_r, mv_nxt;
  logic [15:0] spd_r, spd_nxt;
  logic        coils_r, coils_nxt;
  logic        reach_r, reach_nxt;
  logic        over_r, over_nxt;
  logic        chg_r, chg_nxt;

  logic [OUT_W-1:0] out_r, out_nxt;

  // divider operands
  logic signed [DIVN_W-1:0] div_a;
  logic signed [SW-1:0]     lim_d;
  logic [6:0]               pct_c;
  logic                     div_done;
  logic signed [DIVN_W-1:0] div_q;

  // target step: |limit| * percent, then reciprocal multiply by 1/100
  logic [DIVN_W-1:0]       tm_r, tm_nxt;
  logic [DIVN_W+RCP_W-1:0] tprod;
  logic [SW-1:0]           tq_r, tq_nxt;
  logic signed [SW-1:0]    q_tgt;

  // tick arithmetic
  logic signed [SW-1:0] step_s;
  logic signed [SW-1:0] pos_step;
  logic [SW-1:0]        mag_next;
  logic [SW-1:0]        mag_lim;
  logic                 is_auto;

  assign pct_c  = (tpct_r > PCT_MAX) ? PCT_MAX : tpct_r;
  assign lim_d  = (lim_r == '0) ? SW'(1) : lim_r;

  always_comb begin
    case (cmd.div_sel)
      SEL_TP:  div_a = DIVN_W'(tgt_r) * DIVN_W'(PCT_SCALE);
      default: div_a = DIVN_W'(pos_r) * DIVN_W'(PCT_SCALE);
    endcase
  end

  sbpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (lim_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign tm_nxt = DIVN_W'(mag_lim) * DIVN_W'(pct_c);
  assign tprod  = (DIVN_W+RCP_W)'(tm_r) * (DIVN_W+RCP_W)'(RCP_100);
  assign tq_nxt = tprod[RCP_SH+SW-1:RCP_SH];
  assign q_tgt  = lim_r[SW-1] ? -signed'(tq_r) : signed'(tq_r);

  assign step_s   = (dir_r == DIR_UP) ? -SW'(1) : SW'(1);
  assign pos_step = pos_r + step_s;
  assign mag_next = pos_step[SW-1] ? SW'(-pos_step) : SW'(pos_step);
  assign mag_lim  = lim_r[SW-1] ? SW'(-lim_r) : SW'(lim_r);
  assign is_auto  = (mode_r == MODE_AUTO);

  always_comb begin
    spd_up_nxt = spd_up_r;
    spd_dn_nxt = spd_dn_r;
    inv_nxt    = inv_r;
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    lim_nxt    = lim_r;
    mode_nxt   = mode_r;
    dir_nxt    = dir_r;
    ppct_nxt   = ppct_r;
    tpcr_nxt   = tpcr_r;
    last_nxt   = last_r;
    mv_nxt     = mv_r;
    spd_nxt    = spd_r;
    coils_nxt  = coils_r;
    reach_nxt  = reach_r;
    over_nxt   = over_r;
    chg_nxt    = chg_r;
    out_nxt    = out_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPEED_UP:   spd_up_nxt = cfg_data;
        CFG_SPEED_DOWN: spd_dn_nxt = cfg_data;
        CFG_INVERTED:   inv_nxt    = cfg_data[0];
        default: ;
      endcase
    end

    if (cmd.exec) begin
      mv_nxt    = 2'b00;
      spd_nxt   = '0;
      coils_nxt = 1'b0;
      reach_nxt = 1'b0;
      over_nxt  = 1'b0;
      chg_nxt   = 1'b0;
      case (req_r)
        REQ_TICK: begin
          if (mode_r != MODE_REST) begin
            if (is_auto && pos_r == tgt_r) begin
              tgt_nxt   = pos_r;
              mode_nxt  = MODE_REST;
              coils_nxt = 1'b1;
              reach_nxt = 1'b1;
            end else if (is_auto && mag_next > mag_lim) begin
              tgt_nxt   = pos_r;
              mode_nxt  = MODE_REST;
              coils_nxt = 1'b1;
              over_nxt  = 1'b1;
            end else begin
              spd_nxt = (dir_r == DIR_UP) ? spd_up_r : spd_dn_r;
              mv_nxt  = ((dir_r == DIR_UP) ^ inv_r) ? 2'b11 : 2'b01;
              pos_nxt = pos_step;
            end
          end
        end
        REQ_TARGET: ;
        REQ_UP: begin
          mode_nxt = MODE_MANUAL;
          dir_nxt  = DIR_UP;
        end
        REQ_DOWN: begin
          mode_nxt = MODE_MANUAL;
          dir_nxt  = DIR_DOWN;
        end
        REQ_STOP: begin
          tgt_nxt   = pos_r;
          mode_nxt  = MODE_REST;
          coils_nxt = 1'b1;
        end
        REQ_OPEN: begin
          lim_nxt  = '0;
          pos_nxt  = '0;
          tgt_nxt  = '0;
          mode_nxt = MODE_REST;
        end
        REQ_CLOSED: begin
          lim_nxt  = pos_r;
          tgt_nxt  = pos_r;
          mode_nxt = MODE_REST;
        end
        REQ_LOAD: begin
          pos_nxt = SW'(ld_step_r);
          tgt_nxt = SW'(ld_step_r);
          lim_nxt = SW'(ld_lim_r);
        end
        default: ;
      endcase
    end

    if (cmd.tgt_wr) begin
      tgt_nxt  = q_tgt;
      mode_nxt = MODE_AUTO;
      dir_nxt  = (pos_r < q_tgt) ? DIR_DOWN : DIR_UP;
    end

    if (cmd.tp_wr) begin
      tpcr_nxt = div_q[7:0];
    end

    if (cmd.pp_wr) begin
      ppct_nxt = div_q[7:0];
      if (div_q[7:0] != last_r) begin
        last_nxt = div_q[7:0];
        chg_nxt  = 1'b1;
      end
    end

    if (cmd.out_wr) begin
      out_nxt = {mode_r, lim_r[23:0], pos_r[23:0], chg_r, tpcr_r, ppct_r,
                 over_r, reach_r, coils_r, spd_r, mv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_up_r  <= SPEED_RST;
      spd_dn_r  <= SPEED_RST;
      inv_r     <= 1'b0;
      pos_r     <= '0;
      tgt_r     <= '0;
      lim_r     <= SW'(LIMIT_RST);
      mode_r    <= MODE_REST;
      dir_r     <= DIR_UP;
      ppct_r    <= '0;
      tpcr_r    <= '0;
      last_r    <= '0;
      mv_r      <= '0;
      spd_r     <= '0;
      coils_r   <= 1'b0;
      reach_r   <= 1'b0;
      over_r    <= 1'b0;
      chg_r     <= 1'b0;
    end else begin
      spd_up_r  <= spd_up_nxt;
      spd_dn_r  <= spd_dn_nxt;
      inv_r     <= inv_nxt;
      pos_r     <= pos_nxt;
      tgt_r     <= tgt_nxt;
      lim_r     <= lim_nxt;
      mode_r    <= mode_nxt;
      dir_r     <= dir_nxt;
      ppct_r    <= ppct_nxt;
      tpcr_r    <= tpcr_nxt;
      last_r    <= last_nxt;
      mv_r      <= mv_nxt;
      spd_r     <= spd_nxt;
      coils_r   <= coils_nxt;
      reach_r   <= reach_nxt;
      over_r    <= over_nxt;
      chg_r     <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    tm_r  <= tm_nxt;
    tq_r  <= tq_nxt;
    if (cmd.in_ld) begin
      req_r     <= req_t'(in_tuser);
      tpct_r    <= in_tdata[6:0];
      ld_step_r <= signed'(in_tdata[30:7]);
      ld_lim_r  <= signed'(in_tdata[54:31]);
    end
  end

  assign sts.req      = req_r;
  assign sts.mode     = mode_r;
  assign sts.div_done = div_done;
  assign out_tdata    = out_r;

endmodule

### rtl/sbpc_ctrl.sv
// Controller FSM: sequences command execution, divisions and result hand-off.
// Depends on sbpc_pkg for states and command/status structs.
module sbpc_ctrl import sbpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t st_r, st_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cmd       = '0;
    cmd.div_sel = SEL_TP;
    in_tready = 1'b0;
    ov_nxt    = (ov_r && !out_tready) ? 1'b1 : 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_ld = 1'b1;
          st_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.req == REQ_TARGET) begin
          st_nxt = ST_TGT;
        end else if (sts.req == REQ_LOAD ||
                     (sts.req == REQ_TICK && sts.mode == MODE_AUTO)) begin
          st_nxt = ST_RCS;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_TGT: begin
        st_nxt = ST_TGW;
      end
      ST_TGW: begin
        cmd.tgt_wr = 1'b1;
        st_nxt     = ST_DONE;
      end
      ST_RCS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_TP;
        st_nxt        = ST_RCT;
      end
      ST_RCT: begin
        cmd.div_sel = SEL_PP;
        if (sts.div_done) begin
          cmd.tp_wr     = 1'b1;
          cmd.div_start = 1'b1;
          st_nxt        = ST_RCP;
        end
      end
      ST_RCP: begin
        cmd.div_sel = SEL_PP;
        if (sts.div_done) begin
          cmd.pp_wr = 1'b1;
          st_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          cmd.out_wr = 1'b1;
          ov_nxt     = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ov_r;

endmodule

### rtl/stepper_blind_position_controller.sv
// Stepper blind position controller, top level.
// Uses sbpc_pkg; instantiates sbpc_ctrl and sbpc_dp.
//
// One result transaction per input transaction, one transaction in work at a
// time. Commands that need no division (manual up/down, stop, mark
// open/closed, tick at rest or in manual mode) pass from ST_EXEC straight to
// ST_DONE, where the result is registered and out_tvalid is set. Set target
// passes through ST_TGT and ST_TGW: the target step comes from a reciprocal
// multiply by 1/100, registered in tm_r and then in tq_r. An auto tick or a
// load runs the percent recalculation on the 31-step serial signed divider
// twice (target percent, then position percent). A new transaction is taken
// while the previous result is still held in the output register; the new
// result then waits until that one is accepted, and in_tready stays low
// meanwhile.
module stepper_blind_position_controller import sbpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // target_percent, load_step, load_limit, pad
  input  logic [2:0]       in_tuser,   // req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  // step_move, move_speed, coils_rest, reached_target, overstep, position_pct,
  // target_pct, pct_changed, step_now, limit_now, mode_now
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sbpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sbpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

### dv/tb_top.sv
// Testbench for stepper_blind_position_controller: streams tick and command
// transactions, predicts every status result and checks it field by field.
// Depends on sbpc_pkg and the RTL of the controller only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpc_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    req_t              req;
    logic [6:0]        pct;
    logic signed [23:0] lstep;
    logic signed [23:0] llimit;
  } blind_req_t;

  typedef struct {
    logic [1:0]  step_move;
    logic [15:0] move_speed;
    logic        coils_rest;
    logic        reached;
    logic        overstep;
    logic [7:0]  pos_pct;
    logic [7:0]  tgt_pct;
    logic        pct_changed;
    logic [23:0] step_now;
    logic [23:0] limit_now;
    logic [1:0]  mode_now;
  } blind_status_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [2:0]       in_tuser = REQ_TICK;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [15:0]      cfg_data = '0;

  stepper_blind_position_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted controller state
  logic signed [23:0] m_pos, m_tgt, m_lim;
  mode_t              m_mode;
  dir_t               m_dir;
  logic [7:0]         m_ppct, m_tpct, m_last;
  logic [15:0]        m_spd_up, m_spd_dn;
  logic               m_inv;

  blind_req_t    pending_reqs[$];
  blind_status_t expected_status[$];
  int            err_count = 0;
  int            cycles = 0;

  function automatic logic recalc_percents();
    longint d, tp, pp;
    d = (m_lim != 0) ? longint'(m_lim) : 64'sd1;
    tp = (longint'(m_tgt) * 100) / d;
    pp = (longint'(m_pos) * 100) / d;
    m_tpct = tp[7:0];
    m_ppct = pp[7:0];
    if (m_ppct != m_last) begin
      m_last = m_ppct;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void stop_here();
    m_tgt = m_pos;
    m_mode = MODE_REST;
  endfunction

  function automatic void predict_blind_step(blind_req_t r);
    blind_status_t st;
    logic signed [23:0] nxt;
    logic signed [1:0]  s;
    longint p, t;
    longint an, al;
    logic is_auto;
    st = '{default: '0};
    case (r.req)
      REQ_TICK: begin
        if (m_mode == MODE_AUTO || m_mode == MODE_MANUAL) begin
          is_auto = (m_mode == MODE_AUTO);
          if (is_auto && m_pos == m_tgt) begin
            stop_here();
            st.coils_rest = 1'b1;
            st.reached = 1'b1;
          end else begin
            s = (m_dir == DIR_UP) ? -2'sd1 : 2'sd1;
            nxt = (m_dir == DIR_UP) ? m_pos - 24'sd1 : m_pos + 24'sd1;
            an = longint'(nxt);
            al = longint'(m_lim);
            if (an < 0) an = -an;
            if (al < 0) al = -al;
            if (is_auto && an > al) begin
              stop_here();
              st.coils_rest = 1'b1;
              st.overstep = 1'b1;
            end else begin
              st.move_speed = (m_dir == DIR_UP) ? m_spd_up : m_spd_dn;
              st.step_move = m_inv ? -s : s;
              m_pos = nxt;
            end
          end
          if (is_auto) st.pct_changed = recalc_percents();
        end
      end
      REQ_TARGET: begin
        p = (r.pct > PCT_MAX) ? longint'(PCT_MAX) : longint'(r.pct);
        t = (longint'(m_lim) * p) / 100;
        m_tgt = t[23:0];
        m_mode = MODE_AUTO;
        m_dir = (m_pos < m_tgt) ? DIR_DOWN : DIR_UP;
      end
      REQ_UP: begin
        m_mode = MODE_MANUAL;
        m_dir = DIR_UP;
      end
      REQ_DOWN: begin
        m_mode = MODE_MANUAL;
        m_dir = DIR_DOWN;
      end
      REQ_STOP: begin
        stop_here();
        st.coils_rest = 1'b1;
      end
      REQ_OPEN: begin
        m_lim = '0;
        m_pos = '0;
        m_tgt = '0;
        m_mode = MODE_REST;
      end
      REQ_CLOSED: begin
        m_lim = m_pos;
        m_tgt = m_pos;
        m_mode = MODE_REST;
      end
      default: begin
        m_pos = r.lstep;
        m_tgt = r.lstep;
        m_lim = r.llimit;
        st.pct_changed = recalc_percents();
      end
    endcase
    st.pos_pct = m_ppct;
    st.tgt_pct = m_tpct;
    st.step_now = m_pos;
    st.limit_now = m_lim;
    st.mode_now = m_mode;
    expected_status.push_back(st);
  endfunction

  function automatic void add_req(req_t rq, logic [6:0] p = '0,
                                  logic [23:0] s = '0, logic [23:0] l = '0);
    blind_req_t r;
    r.req = rq;
    r.pct = p;
    r.lstep = s;
    r.llimit = l;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [23:0] near_zero();
    int v;
    v = int'($urandom_range(0, 120)) - 60;
    return v[23:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SPEED_UP:   m_spd_up = val;
      CFG_SPEED_DOWN: m_spd_dn = val;
      CFG_INVERTED:   m_inv = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  function automatic void queue_directed();
    add_req(REQ_TICK);                         // tick at rest
    add_req(REQ_TARGET, 7'd50);
    add_req(REQ_TICK);
    add_req(REQ_STOP);
    add_req(REQ_LOAD, 7'd0, 24'd3, 24'd6);
    add_req(REQ_TARGET, 7'd127);               // clamped to 100
    repeat (4) add_req(REQ_TICK);
    add_req(REQ_TICK);                         // at rest after the arrival
    add_req(REQ_LOAD, 7'd0, 24'd30, 24'd20);
    add_req(REQ_TARGET, 7'd100);
    add_req(REQ_TICK);                         // refused beyond limit
    add_req(REQ_LOAD, 7'd0, 24'd0, 24'd0);     // zero limit
    add_req(REQ_TARGET, 7'd0);
    add_req(REQ_TICK);
    add_req(REQ_LOAD, 7'h7F, 24'h7FFFFF, 24'h800000);
    add_req(REQ_DOWN);
    add_req(REQ_TICK);                         // wraps to most negative
    add_req(REQ_UP);
    add_req(REQ_TICK);
    add_req(REQ_CLOSED);
    add_req(REQ_OPEN);
    add_req(REQ_LOAD, 7'd0, 24'h800000, 24'h7FFFFF);
  endfunction

  task automatic queue_random(int n);
    int goal, k, r;
    goal = pending_reqs.size() + n;
    while (pending_reqs.size() < goal) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 99) < 60) add_req(REQ_LOAD, 7'($urandom), near_zero(), near_zero());
        add_req(REQ_TARGET, ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                        : 7'($urandom_range(0, 100)));
        k = $urandom_range(1, 60);
        repeat (k) begin
          if ($urandom_range(0, 49) == 0) add_req(req_t'($urandom_range(2, 6)));
          else add_req(REQ_TICK);
        end
      end else if (r < 75) begin
        add_req($urandom_range(0, 1) ? REQ_UP : REQ_DOWN);
        repeat ($urandom_range(1, 12)) add_req(REQ_TICK);
        if ($urandom_range(0, 99) < 70) add_req(REQ_STOP);
      end else if (r < 85) begin
        if ($urandom_range(0, 1)) begin
          add_req(REQ_OPEN);
          add_req($urandom_range(0, 1) ? REQ_UP : REQ_DOWN);
          repeat ($urandom_range(1, 40)) add_req(REQ_TICK);
          add_req(REQ_CLOSED);
        end else begin
          add_req(REQ_LOAD, 7'($urandom), near_zero(), near_zero());
          add_req(REQ_CLOSED);
        end
        add_req(REQ_TARGET, 7'($urandom_range(0, 100)));
        repeat ($urandom_range(1, 40)) add_req(REQ_TICK);
      end else begin
        repeat ($urandom_range(1, 4))
          add_req(req_t'($urandom_range(0, 7)), 7'($urandom), 24'($urandom), 24'($urandom));
      end
    end
  endtask

  // input driver
  int         tx_idle = 0;
  int         tx_burst = 0;
  blind_req_t drv_cur;

  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_blind_step(drv_cur);
      if (in_tvalid && !in_tready) begin
        offer = 1'b1;
      end else if (tx_idle > 0) begin
        tx_idle--;
      end else if (pending_reqs.size() > 0) begin
        drv_cur = pending_reqs.pop_front();
        in_tuser <= drv_cur.req;
        in_tdata <= {1'b0, drv_cur.llimit, drv_cur.lstep, drv_cur.pct};
        offer = 1'b1;
        if (tx_burst > 0) begin
          tx_burst--;
        end else if ($urandom_range(0, 59) == 0) begin
          tx_burst = $urandom_range(20, 100);
        end else if ($urandom_range(0, 99) >= 50) begin
          tx_idle = pick_gap();
        end
      end
      in_tvalid <= offer;
    end
  end

  // result-side backpressure, with one long hold-off
  int rx_seen = 0;
  int rx_stall = 0;
  int rx_hold = 0;
  int rx_burst = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) rx_seen++;
      if (!hold_done && rx_seen >= 400) begin
        hold_done = 1'b1;
        rx_hold = 600;
      end
      if (rx_hold > 0) begin
        rx_hold--;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else begin
        rdy = 1'b1;
        if (rx_burst > 0) rx_burst--;
        else if ($urandom_range(0, 199) == 0) rx_burst = $urandom_range(30, 150);
        else if ($urandom_range(0, 99) < 20) rx_stall = pick_gap();
      end
    end
    out_tready <= rdy;
  end

  task automatic check_field(string nm, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
      err_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    blind_status_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, actual %0h", $time, out_tdata);
        err_count++;
      end else begin
        w = expected_status.pop_front();
        check_field("step_move", w.step_move, out_tdata[1:0]);
        check_field("move_speed", w.move_speed, out_tdata[17:2]);
        check_field("coils_rest", w.coils_rest, out_tdata[18]);
        check_field("reached_target", w.reached, out_tdata[19]);
        check_field("overstep", w.overstep, out_tdata[20]);
        check_field("position_pct", w.pos_pct, out_tdata[28:21]);
        check_field("target_pct", w.tgt_pct, out_tdata[36:29]);
        check_field("pct_changed", w.pct_changed, out_tdata[37]);
        check_field("step_now", w.step_now, out_tdata[61:38]);
        check_field("limit_now", w.limit_now, out_tdata[85:62]);
        check_field("mode_now", w.mode_now, out_tdata[87:86]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_status.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    m_pos = '0;
    m_tgt = '0;
    m_lim = 24'(LIMIT_RST);
    m_mode = MODE_REST;
    m_dir = DIR_UP;
    m_ppct = '0;
    m_tpct = '0;
    m_last = '0;
    m_spd_up = SPEED_RST;
    m_spd_dn = SPEED_RST;
    m_inv = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_SPEED_UP, 16'h0000);
          write_reg(CFG_SPEED_DOWN, 16'hFFFF);
          write_reg(CFG_INVERTED, 16'h0001);
          write_reg(CFG_UNUSED, 16'($urandom));
        end
        2: begin
          write_reg(CFG_SPEED_UP, 16'hFFFF);
          write_reg(CFG_SPEED_DOWN, 16'h0000);
          write_reg(CFG_INVERTED, 16'h0000);
        end
        default: begin
          write_reg(CFG_SPEED_UP, 16'($urandom));
          write_reg(CFG_SPEED_DOWN, 16'($urandom));
          write_reg(CFG_INVERTED, 16'($urandom));
        end
      endcase
      if (ph == 0) queue_directed();
      queue_random(320);
      wait_drained();
      repeat (10) @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (err_count == 0 && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
